// ===== hw/rtl/vtp_pkg.sv =====
package vtp_pkg;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		CFG_MANUAL_MODE     = 3'd0,
		CFG_MANUAL_TARGET   = 3'd1,
		CFG_ADVANCED_STYLE  = 3'd2,
		CFG_OPEN_THRESHOLD  = 3'd3,
		CFG_CLOSE_THRESHOLD = 3'd4,
		CFG_SEAL_THRESHOLD  = 3'd5,
		CFG_RULE_COUNT      = 3'd6
	} cfg_idx_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 15;

	typedef struct packed {
		op_t                operation;
		logic               status_reliable;
		logic               printer_error;
		logic               print_active;
		logic               chamber_heat_on;
		logic signed [15:0] bed_reading;
		logic [14:0]        bed_setpoint;
		logic [63:0]        material_bytes;
		logic [3:0]         rule_slot;
		logic [63:0]        rule_name;
		logic               rule_seals;
	} item_t;

	typedef struct packed {
		logic vent_target;
		logic target_changed;
	} result_t;

	typedef struct packed {
		logic        manual_mode;
		logic        manual_target;
		logic        advanced_style;
		logic [14:0] open_threshold;
		logic [14:0] close_threshold;
		logic [13:0] seal_threshold;
		logic [4:0]  rule_count;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		manual_mode:     1'b0,
		manual_target:   1'b0,
		advanced_style:  1'b0,
		open_threshold:  15'd4500,
		close_threshold: 15'd3500,
		seal_threshold:  14'd8500,
		rule_count:      5'd9
	};

	typedef struct packed {
		logic        en;
		logic [3:0]  slot;
		logic [63:0] name;
		logic        seals;
	} rule_wr_t;

	typedef struct packed {
		logic hit;
		logic seals;
	} rule_pref_t;

	// default rules, first character in the lowest byte
	localparam int DEF_RULES = 9;
	localparam logic [DEF_RULES-1:0][63:0] DEF_RULE_NAME = '{
		64'h0000_0000_5350_4948, // HIPS
		64'h0000_0000_0000_4150, // PA
		64'h0000_0000_0000_4350, // PC
		64'h0000_0000_0041_5341, // ASA
		64'h0000_0000_0053_4241, // ABS
		64'h0000_0000_0055_5054, // TPU
		64'h0000_0000_0054_4550, // PET
		64'h0000_0000_4754_4550, // PETG
		64'h0000_0000_0041_4C50  // PLA
	};
	localparam logic [DEF_RULES-1:0] DEF_RULE_SEALS = 9'b1_1111_0000;

	// upper-case a-z, everything from the first zero byte on reads as zero
	function automatic logic [63:0] upcase_name(input logic [63:0] raw);
		logic [63:0] res;
		logic        live;
		logic [7:0]  b;
		res  = '0;
		live = 1'b1;
		for (int i = 0; i < 8; i++) begin
			b = raw[8*i +: 8];
			if (b == 8'h00) begin
				live = 1'b0;
			end
			if (b >= 8'h61 && b <= 8'h7A) begin
				b = b - 8'h20;
			end
			if (live) begin
				res[8*i +: 8] = b;
			end
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/vtp_rule_table.sv =====
module vtp_rule_table
	import vtp_pkg::*;
#(
	parameter int RULE_SLOTS = 16,
	parameter int NAME_BYTES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  rule_wr_t   wr,
	input  logic [63:0] material,
	input  logic [4:0] rule_count,
	output rule_pref_t pref
);

	localparam int NAME_W = NAME_BYTES * 8;
	localparam int IDX_W  = 7;

	logic [RULE_SLOTS-1:0][NAME_W-1:0] name_q;
	logic [RULE_SLOTS-1:0]             seals_q;
	logic [RULE_SLOTS-1:0]             hit;
	logic [63:0]                       wr_up;
	logic [63:0]                       mat_up;

	assign wr_up  = upcase_name(wr.name);
	assign mat_up = upcase_name(material);

	for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_entry
		localparam logic [NAME_W-1:0] RST_NAME =
			(i < DEF_RULES) ? DEF_RULE_NAME[i % DEF_RULES][NAME_W-1:0] : '0;
		localparam logic RST_SEALS =
			(i < DEF_RULES) ? DEF_RULE_SEALS[i % DEF_RULES] : 1'b0;

		logic [NAME_BYTES-1:0] byte_bad;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				name_q[i]  <= RST_NAME;
				seals_q[i] <= RST_SEALS;
			end else if (wr.en && {3'b000, wr.slot} == IDX_W'(i)) begin
				name_q[i]  <= wr_up[NAME_W-1:0];
				seals_q[i] <= wr.seals;
			end
		end

		// stored names are zero past their end, so a prefix test is a per-byte test
		always_comb begin
			for (int k = 0; k < NAME_BYTES; k++) begin
				byte_bad[k] = (name_q[i][8*k +: 8] != 8'h00) &&
					(name_q[i][8*k +: 8] != mat_up[8*k +: 8]);
			end
		end

		assign hit[i] = (IDX_W'(i) < {2'b00, rule_count}) &&
			(name_q[i][7:0] != 8'h00) && (byte_bad == '0);
	end

	// first matching slot wins
	always_comb begin
		pref = '0;
		for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				pref.hit   = 1'b1;
				pref.seals = seals_q[i];
			end
		end
	end

endmodule

// ===== hw/rtl/vtp_decide.sv =====
module vtp_decide
	import vtp_pkg::*;
(
	input  cfg_t       cfg,
	input  item_t      item,
	input  logic       cur_target,
	input  rule_pref_t pref,
	output logic       want
);

	logic has_target;
	logic bed_rule;
	logic above_open;
	logic below_close;

	assign has_target  = item.bed_setpoint != 15'd0;
	assign bed_rule    = !(item.bed_setpoint >= {1'b0, cfg.seal_threshold});
	assign above_open  = item.bed_reading > $signed({1'b0, cfg.open_threshold});
	assign below_close = item.bed_reading < $signed({1'b0, cfg.close_threshold});

	always_comb begin
		if (cfg.manual_mode) begin
			want = cfg.manual_target;
		end else if (!item.status_reliable || item.printer_error) begin
			want = cur_target;
		end else if (item.chamber_heat_on) begin
			want = 1'b0;
		end else if (has_target && !cfg.advanced_style) begin
			want = bed_rule;
		end else if (item.print_active) begin
			if (cfg.advanced_style && pref.hit) begin
				want = !pref.seals;
			end else if (has_target) begin
				want = bed_rule;
			end else begin
				want = cur_target;
			end
		end else if (above_open) begin
			want = 1'b1;
		end else if (below_close) begin
			want = 1'b0;
		end else begin
			want = cur_target;
		end
	end

endmodule

// ===== hw/rtl/vent_target_policy_top.sv =====
// Enclosure vent target policy. Each beat on the item channel is either a status tick
// or a material rule write. A tick is taken into an input register, decided
// combinationally against the configuration, the rule table and the current target,
// and its result is written to the output register; one item can be taken every cycle
// unless a tick waits on a stalled result, and the output register lets a new item in
// while an older result waits. A rule write upper-cases the name, updates the table in
// the cycle after acceptance, and gives no result; ticks behind it see the new rule.
// Configuration writes are registered and must only be made while the block is idle.
module vent_target_policy_top
	import vtp_pkg::*;
#(
	parameter int RULE_SLOTS = 16,
	parameter int NAME_BYTES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result
);

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	logic       s1_tick;
	logic       s1_go;
	logic       cur_target_q;
	logic       want;
	rule_pref_t pref;
	rule_wr_t   rule_wr;
	result_t    result_q;
	logic       result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MANUAL_MODE:     cfg_q.manual_mode     <= cfg_data[0];
				CFG_MANUAL_TARGET:   cfg_q.manual_target   <= cfg_data[0];
				CFG_ADVANCED_STYLE:  cfg_q.advanced_style  <= cfg_data[0];
				CFG_OPEN_THRESHOLD:  cfg_q.open_threshold  <= cfg_data;
				CFG_CLOSE_THRESHOLD: cfg_q.close_threshold <= cfg_data;
				CFG_SEAL_THRESHOLD:  cfg_q.seal_threshold  <= cfg_data[13:0];
				CFG_RULE_COUNT:      cfg_q.rule_count      <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// rule writes never wait on the result side
	assign s1_tick    = valid_s1 && (item_s1.operation == OP_TICK);
	assign s1_go      = valid_s1 && (!s1_tick || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	assign rule_wr.en    = s1_go && (item_s1.operation == OP_WRITE);
	assign rule_wr.slot  = item_s1.rule_slot;
	assign rule_wr.name  = item_s1.rule_name;
	assign rule_wr.seals = item_s1.rule_seals;

	vtp_rule_table #(
		.RULE_SLOTS(RULE_SLOTS),
		.NAME_BYTES(NAME_BYTES)
	) u_rules (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (rule_wr),
		.material  (item_s1.material_bytes),
		.rule_count(cfg_q.rule_count),
		.pref      (pref)
	);

	vtp_decide u_decide (
		.cfg       (cfg_q),
		.item      (item_s1),
		.cur_target(cur_target_q),
		.pref      (pref),
		.want      (want)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_target_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (s1_go && s1_tick) begin
			cur_target_q   <= want;
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_tick) begin
			result_q.vent_target    <= want;
			result_q.target_changed <= want != cur_target_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hw/rtl/vtp_checker.sv =====
module vtp_checker
	import vtp_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input item_t   item,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	logic last_target_q;

	// target carried by the last delivered result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_target_q <= 1'b0;
		end else if (result_valid && result_ready) begin
			last_target_q <= result.vent_target;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat dropped or changed while stalled");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.target_changed == (result.vent_target != last_target_q))
		else $error("target_changed disagrees with previous delivered target");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |->
			$past(item_valid && item_ready && item.operation == OP_TICK, 2))
		else $error("result appeared without a tick two cycles earlier");

endmodule

bind vent_target_policy_top vtp_checker u_vtp_checker (.*);

// ===== tb/tb.sv =====
module tb;
	import vtp_pkg::*;

	class vent_decision_board;
		typedef enum {LEAN_NONE, LEAN_OPEN, LEAN_SEAL} lean_e;

		cfg_t        regs;
		logic        vent_now;
		logic [63:0] rule_names [16];
		logic        rule_seal [16];
		result_t     expected_targets [$];
		int          mismatches;
		int          ticks_seen;
		int          writes_seen;
		int          results_seen;

		function new();
			regs = '{manual_mode: 1'b0, manual_target: 1'b0, advanced_style: 1'b0,
				open_threshold: 15'd4500, close_threshold: 15'd3500,
				seal_threshold: 14'd8500, rule_count: 5'd9};
			vent_now = 1'b0;
			for (int i = 0; i < 16; i++) begin
				rule_names[i] = '0;
				rule_seal[i] = 1'b0;
			end
			// built-in materials, first letter in the low byte
			rule_names[0] = 64'h414C50;   // PLA
			rule_names[1] = 64'h47544550; // PETG
			rule_names[2] = 64'h544550;   // PET
			rule_names[3] = 64'h555054;   // TPU
			rule_names[4] = 64'h534241;   // ABS
			rule_names[5] = 64'h415341;   // ASA
			rule_names[6] = 64'h4350;     // PC
			rule_names[7] = 64'h4150;     // PA
			rule_names[8] = 64'h53504948; // HIPS
			for (int i = 4; i < 9; i++) begin
				rule_seal[i] = 1'b1;
			end
			mismatches = 0;
			ticks_seen = 0;
			writes_seen = 0;
			results_seen = 0;
		endfunction

		// upper-case a-z, stop at the first zero byte
		function logic [63:0] fold_upper(logic [63:0] raw);
			logic [63:0] folded;
			logic [7:0]  b;
			folded = '0;
			for (int i = 0; i < 8; i++) begin
				b = raw[8*i +: 8];
				if (b == 8'h00) break;
				if (b >= 8'h61 && b <= 8'h7A) b = b - 8'h20;
				folded[8*i +: 8] = b;
			end
			return folded;
		endfunction

		// first rule whose name is a prefix of the material
		function lean_e material_lean(logic [63:0] material);
			logic [63:0] up;
			logic [7:0]  rb;
			int          n;
			bit          any;
			bit          hit;
			up = fold_upper(material);
			n = (regs.rule_count > 16) ? 16 : int'(regs.rule_count);
			if (up[7:0] == 8'h00) return LEAN_NONE;
			for (int i = 0; i < n; i++) begin
				any = 1'b0;
				hit = 1'b1;
				for (int k = 0; k < 8; k++) begin
					rb = rule_names[i][8*k +: 8];
					if (rb == 8'h00) break;
					any = 1'b1;
					if (rb != up[8*k +: 8]) begin
						hit = 1'b0;
						break;
					end
				end
				if (any && hit) return rule_seal[i] ? LEAN_SEAL : LEAN_OPEN;
			end
			return LEAN_NONE;
		endfunction

		function logic setpoint_vent(logic [14:0] tgt);
			return (int'(tgt) >= int'(regs.seal_threshold)) ? 1'b0 : 1'b1;
		endfunction

		function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_MANUAL_MODE:     regs.manual_mode = val[0];
				CFG_MANUAL_TARGET:   regs.manual_target = val[0];
				CFG_ADVANCED_STYLE:  regs.advanced_style = val[0];
				CFG_OPEN_THRESHOLD:  regs.open_threshold = val[14:0];
				CFG_CLOSE_THRESHOLD: regs.close_threshold = val[14:0];
				CFG_SEAL_THRESHOLD:  regs.seal_threshold = val[13:0];
				CFG_RULE_COUNT:      regs.rule_count = val[4:0];
				default: ;
			endcase
		endfunction

		function void take_item(item_t it);
			logic    want;
			lean_e   lean;
			int      temp;
			result_t res;
			if (it.operation == OP_WRITE) begin
				rule_names[it.rule_slot] = fold_upper(it.rule_name);
				rule_seal[it.rule_slot] = it.rule_seals;
				writes_seen++;
				return;
			end
			temp = $signed(it.bed_reading);
			if (regs.manual_mode) begin
				want = regs.manual_target;
			end else if (!it.status_reliable || it.printer_error) begin
				want = vent_now;
			end else if (it.chamber_heat_on) begin
				want = 1'b0;
			end else if (it.bed_setpoint != 0 && !regs.advanced_style) begin
				want = setpoint_vent(it.bed_setpoint);
			end else if (it.print_active) begin
				lean = regs.advanced_style ? material_lean(it.material_bytes) : LEAN_NONE;
				if (lean == LEAN_SEAL) want = 1'b0;
				else if (lean == LEAN_OPEN) want = 1'b1;
				else if (it.bed_setpoint != 0) want = setpoint_vent(it.bed_setpoint);
				else want = vent_now;
			end else if (temp > int'(regs.open_threshold)) begin
				want = 1'b1;
			end else if (temp < int'(regs.close_threshold)) begin
				want = 1'b0;
			end else begin
				want = vent_now;
			end
			res.vent_target = want;
			res.target_changed = (want != vent_now);
			expected_targets.push_back(res);
			vent_now = want;
			ticks_seen++;
		endfunction

		task report(string msg);
			if (mismatches < 100) $display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_result(result_t r);
			result_t want;
			if (expected_targets.size() == 0) begin
				report($sformatf("result %b with nothing pending", r));
				return;
			end
			want = expected_targets.pop_front();
			results_seen++;
			if (r.vent_target !== want.vent_target)
				report($sformatf("result %0d vent_target %b, want %b",
					results_seen, r.vent_target, want.vent_target));
			if (r.target_changed !== want.target_changed)
				report($sformatf("result %0d target_changed %b, want %b",
					results_seen, r.target_changed, want.target_changed));
		endtask

		function int pending();
			return expected_targets.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   item_valid;
	logic                   item_ready;
	item_t                  item;
	logic                   result_valid;
	logic                   result_ready;
	result_t                result;

	vent_decision_board board;
	int                 idle_mode;
	int                 stall_left;
	int                 settings_used;

	vent_target_policy_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (item_valid && item_ready) board.take_item(item);
		if (result_valid && result_ready) board.check_result(result);
	end

	// receiver stalls
	initial begin
		result_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				if (idle_mode != 0 &&
						$urandom_range(0, 99) < ((idle_mode == 1) ? 10 : 35)) begin
					if ($urandom_range(0, 9) != 0) stall_left = $urandom_range(1, 3);
					else stall_left = $urandom_range(5, 30);
				end
			end
		end
	end

	function automatic logic [63:0] pack_name(string s);
		logic [63:0] n;
		n = '0;
		for (int i = 0; i < s.len() && i < 8; i++) begin
			n[8*i +: 8] = s[i];
		end
		return n;
	endfunction

	function automatic int sender_gap();
		int r;
		if (idle_mode == 0) return 0;
		r = $urandom_range(0, 99);
		if (r < ((idle_mode == 1) ? 70 : 40)) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic item_t make_tick(bit rel, bit err, bit act, bit heat,
			int temp, int tgt, logic [63:0] material);
		item_t it;
		it.operation = OP_TICK;
		it.status_reliable = rel;
		it.printer_error = err;
		it.print_active = act;
		it.chamber_heat_on = heat;
		it.bed_reading = 16'(temp);
		it.bed_setpoint = 15'(tgt);
		it.material_bytes = material;
		it.rule_slot = 4'($urandom_range(0, 15));
		it.rule_name = {$urandom, $urandom};
		it.rule_seals = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic item_t make_rule(int slot, logic [63:0] name, bit seals);
		item_t it;
		it = make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			$urandom_range(0, 65535), $urandom_range(0, 32767), {$urandom, $urandom});
		it.operation = OP_WRITE;
		it.rule_slot = 4'(slot);
		it.rule_name = name;
		it.rule_seals = seals;
		return it;
	endfunction

	// short names from a small alphabet so they collide with materials
	function automatic logic [63:0] rand_name(int maxlen);
		string       abc = "PLAETGUBSCHIpaletgubschi@[`{-+0z";
		logic [63:0] n;
		int          len;
		n = '0;
		len = $urandom_range(0, maxlen);
		for (int i = 0; i < len; i++) begin
			n[8*i +: 8] = abc[$urandom_range(0, abc.len() - 1)];
		end
		// junk behind the terminator
		if (len < 7 && $urandom_range(0, 3) == 0)
			n[8*(len+1) +: 8] = 8'($urandom_range(1, 255));
		return n;
	endfunction

	function automatic logic [63:0] rand_material();
		string       known [14] = '{"PLA", "PLA+", "PETG", "PETG-CF", "PET", "PCTG",
			"TPU", "ABS", "ASA", "PC", "PA6-GF", "PA", "HIPS", "NYLON"};
		logic [63:0] n;
		logic [7:0]  b;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				n = pack_name(known[$urandom_range(0, 13)]);
				for (int i = 0; i < 8; i++) begin
					b = n[8*i +: 8];
					if (b >= 8'h41 && b <= 8'h5A && $urandom_range(0, 1) == 1)
						n[8*i +: 8] = b + 8'h20;
				end
			end
			5, 6, 7: n = rand_name(8);
			8: n = {$urandom, 24'($urandom), 8'h00};
			default: n = {$urandom, $urandom};
		endcase
		return n;
	endfunction

	function automatic int rand_temp();
		case ($urandom_range(0, 5))
			0: return int'(board.regs.open_threshold) + int'($urandom_range(0, 6)) - 3;
			1: return int'(board.regs.close_threshold) + int'($urandom_range(0, 6)) - 3;
			2, 3: return int'($urandom_range(0, 34000)) - 4000;
			4: return $urandom_range(0, 65535);
			default: return int'($urandom_range(0, 4)) - 2;
		endcase
	endfunction

	function automatic int rand_target();
		case ($urandom_range(0, 4))
			0, 1: return 0;
			2: return int'(board.regs.seal_threshold) + int'($urandom_range(0, 4)) - 2;
			3: return $urandom_range(1, 30000);
			default: return $urandom_range(0, 32767);
		endcase
	endfunction

	function automatic item_t random_item();
		logic [63:0] name;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 7))
				0: name = {$urandom, $urandom};
				1: name = '0;
				default: name = rand_name(4);
			endcase
			return make_rule($urandom_range(0, 15), name, 1'($urandom_range(0, 1)));
		end
		return make_tick($urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
			1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
			rand_temp(), rand_target(), rand_material());
	endfunction

	function automatic cfg_t phase_setting(int p);
		cfg_t c;
		c = '{manual_mode: 1'b0, manual_target: 1'b0, advanced_style: 1'b1,
			open_threshold: 15'd4500, close_threshold: 15'd3500,
			seal_threshold: 14'd8500, rule_count: 5'd9};
		case (p)
			1: ;
			2: begin
				c.manual_mode = 1'b1;
				c.manual_target = 1'b1;
			end
			3: begin
				c.manual_mode = 1'b1;
				c.advanced_style = 1'b0;
			end
			4: begin
				c.open_threshold = 15'd0;
				c.close_threshold = 15'd20000;
				c.seal_threshold = 14'd4000;
				c.rule_count = 5'd31;
			end
			5: begin
				c.manual_target = 1'b1;
				c.advanced_style = 1'b0;
				c.open_threshold = 15'd20000;
				c.close_threshold = 15'd0;
				c.seal_threshold = 14'd12000;
				c.rule_count = 5'd0;
			end
			6: begin
				c.open_threshold = 15'd3000;
				c.close_threshold = 15'd3000;
				c.seal_threshold = 14'd16383;
				c.rule_count = 5'd16;
			end
			default: begin
				c.advanced_style = 1'($urandom_range(0, 1));
				c.open_threshold = 15'($urandom_range(0, 20000));
				c.close_threshold = 15'($urandom_range(0, 20000));
				c.seal_threshold = 14'($urandom_range(4000, 12000));
				c.rule_count = 5'($urandom_range(0, 31));
			end
		endcase
		return c;
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_ready !== 1'b1);
	endtask

	task automatic write_one(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		board.set_register(idx, val);
	endtask

	task automatic write_regs(cfg_t c);
		write_one(CFG_MANUAL_MODE, 15'(c.manual_mode));
		write_one(CFG_MANUAL_TARGET, 15'(c.manual_target));
		write_one(CFG_ADVANCED_STYLE, 15'(c.advanced_style));
		write_one(CFG_OPEN_THRESHOLD, c.open_threshold);
		write_one(CFG_CLOSE_THRESHOLD, c.close_threshold);
		write_one(CFG_SEAL_THRESHOLD, 15'(c.seal_threshold));
		write_one(CFG_RULE_COUNT, 15'(c.rule_count));
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_quiet();
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// reset settings: simple style
	task automatic simple_directed();
		send_item(make_tick(0, 0, 0, 0, 10000, 0, '0));
		send_item(make_tick(1, 1, 1, 0, 10000, 100, '0));
		send_item(make_tick(1, 0, 0, 1, 10000, 100, '0));
		send_item(make_tick(1, 0, 0, 0, 0, 8499, '0));
		send_item(make_tick(1, 0, 1, 0, 0, 8500, '0));
		send_item(make_tick(1, 0, 0, 0, 0, 32767, '0));
		send_item(make_tick(1, 0, 0, 0, 4501, 0, '0));
		send_item(make_tick(1, 0, 0, 0, 3500, 0, '0));
		send_item(make_tick(1, 0, 0, 0, -32768, 0, '0));
		send_item(make_tick(1, 0, 0, 0, 4500, 0, '0));
		send_item(make_tick(1, 0, 0, 0, 32767, 0, '0));
		send_item(make_tick(1, 0, 1, 0, -4000, 0, pack_name("ABS")));
	endtask

	// advanced style: material prefix rules
	task automatic material_directed();
		send_item(make_tick(1, 0, 1, 0, 0, 0, pack_name("abs")));
		send_item(make_tick(1, 0, 1, 0, 0, 0, pack_name("pla")));
		send_item(make_tick(1, 0, 1, 0, 0, 0, pack_name("PCTG")));
		send_item(make_tick(1, 0, 1, 0, 0, 0, pack_name("petx")));
		send_item(make_tick(1, 0, 1, 0, 0, 0, pack_name("HIPS")));
		send_item(make_tick(1, 0, 1, 0, 0, 0, pack_name("P")));
		send_item(make_tick(1, 0, 1, 0, 0, 200, 64'h4241_00));
		send_item(make_tick(1, 0, 1, 0, 0, 9000, pack_name("X")));
		send_item(make_rule(0, '0, 1'b1));
		send_item(make_tick(1, 0, 1, 0, 0, 100, pack_name("PLA")));
		send_item(make_rule(1, pack_name("ab") | (64'h6463 << 24), 1'b1));
		send_item(make_tick(1, 0, 1, 0, 0, 0, pack_name("abc")));
		send_item(make_tick(1, 0, 1, 0, 0, 0, pack_name("petg")));
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		idle_mode = 0;
		settings_used = 1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < 9; phase++) begin
			idle_mode = phase % 3;
			if (phase > 0) write_regs(phase_setting(phase));
			if (phase == 0) simple_directed();
			if (phase == 1) material_directed();
			repeat (180) send_item(random_item());
			@(negedge clk);
			item_valid <= 1'b0;
			wait_quiet();
		end
		$display("ran %0d status ticks and %0d rule writes under %0d register settings",
			board.ticks_seen, board.writes_seen, settings_used);
		$display("checked %0d results, %0d mismatches", board.results_seen, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== vent_target_policy_top.f =====
hw/rtl/vtp_pkg.sv
hw/rtl/vtp_rule_table.sv
hw/rtl/vtp_decide.sv
hw/rtl/vent_target_policy_top.sv
hw/rtl/vtp_checker.sv
tb/tb.sv
